// ===== design/overlay_scaler_register_calc_defines.svh =====
// assertion macros for the overlay scaler register calculator
`ifndef OVERLAY_SCALER_REGISTER_CALC_DEFINES_SVH
`define OVERLAY_SCALER_REGISTER_CALC_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define OSRC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define OSRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/osrc_pkg.sv =====
// package with payload types and register constants of the overlay scaler calculator
package osrc_pkg;

    localparam int NumWrites = 17;
    localparam int DivSteps  = 24;

    typedef struct packed {
        logic [10:0] src_width;
        logic [9:0]  src_height;
        logic [11:0] dst_width;
        logic [11:0] dst_height;
        logic [11:0] dst_x;
        logic [11:0] dst_y;
        logic [1:0]  pixel_format;
        logic        deinterlace;
        logic [31:0] base_address;
        logic [14:0] line_pitch;
        logic [2:0]  held_command_bits;
    } osrc_in_t;

    typedef struct packed {
        logic [4:0]  register_index;
        logic [31:0] register_value;
        logic        last_write;
    } osrc_out_t;

    // restoring divider lane: dividend shifts out, quotient shifts in
    typedef struct packed {
        logic        valid;
        logic [23:0] num;
        logic [12:0] rem;
        logic [23:0] quo;
        logic [11:0] den;
    } osrc_div_t;

    localparam logic [1:0] FmtI420 = 2'd0;
    localparam logic [1:0] FmtYv12 = 2'd1;
    localparam logic [1:0] FmtYuy2 = 2'd2;
    localparam logic [1:0] FmtUyvy = 2'd3;

    localparam logic [31:0] ScaleOne  = 32'h8000_4000;
    localparam logic [31:0] Phase420  = 32'h3000_3000;
    localparam logic [31:0] VcMask    = 32'h7000_0000;
    localparam logic [31:0] VcUp      = 32'h2000_0000;
    localparam logic [31:0] VcDown    = 32'h6000_0000;
    localparam logic [31:0] VlMask    = 32'h0E00_0000;
    localparam logic [31:0] VlUp      = 32'h0400_0000;
    localparam logic [31:0] VlDown    = 32'h0C00_0000;
    localparam logic [31:0] HcMask    = 32'h01C0_0000;
    localparam logic [31:0] HcUp      = 32'h0080_0000;
    localparam logic [31:0] HcDown    = 32'h0180_0000;
    localparam logic [31:0] HlMask    = 32'h0038_0000;
    localparam logic [31:0] HlUp      = 32'h0010_0000;
    localparam logic [31:0] HlDown    = 32'h0030_0000;
    localparam logic [31:0] YAdj      = 32'h0001_0000;
    localparam logic [31:0] ByteOrder = 32'h0000_C000;
    localparam logic [31:0] YSwap     = 32'h0000_8000;
    localparam logic [31:0] FmtMask   = 32'h0000_3C00;
    localparam logic [31:0] Fmt422    = 32'h0000_2000;
    localparam logic [31:0] Fmt420    = 32'h0000_3000;
    localparam logic [31:0] FieldBit  = 32'h0000_0020;
    localparam logic [11:0] LineBufLimit = 12'd720;

endpackage

// ===== design/osrc_div_cell.sv =====
// one restoring-division cell: a quotient bit per cycle for two lanes while not stalled
module osrc_div_cell import osrc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      stall,
    input  osrc_div_t x_in,
    input  osrc_div_t y_in,
    output osrc_div_t x_out,
    output osrc_div_t y_out
);

    osrc_div_t x_reg, y_reg, x_next, y_next;

    function automatic osrc_div_t step(osrc_div_t d);
        osrc_div_t  r;
        logic [12:0] t;
        r = d;
        t = {d.rem[11:0], d.num[23]};
        r.num = {d.num[22:0], 1'b0};
        if (t >= {1'b0, d.den}) begin
            r.rem = t - {1'b0, d.den};
            r.quo = {d.quo[22:0], 1'b1};
        end else begin
            r.rem = t;
            r.quo = {d.quo[22:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit per lane
    always_comb begin
        x_next = step(x_in);
        y_next = step(y_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg.valid <= 1'b0;
            y_reg.valid <= 1'b0;
        end else if (!stall) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

// ===== design/osrc_div_chain.sv =====
// chain of division cells computing both scale quotients
module osrc_div_chain import osrc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      stall,
    input  osrc_div_t x_in,
    input  osrc_div_t y_in,
    output osrc_div_t x_out,
    output osrc_div_t y_out
);

    osrc_div_t xs [DivSteps+1];
    osrc_div_t ys [DivSteps+1];

    assign xs[0] = x_in;
    assign ys[0] = y_in;

    // row of identical cells
    for (genvar g = 0; g < DivSteps; g++) begin : g_cell
        osrc_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .stall(stall),
            .x_in(xs[g]), .y_in(ys[g]), .x_out(xs[g+1]), .y_out(ys[g+1])
        );
    end

    assign x_out = xs[DivSteps];
    assign y_out = ys[DivSteps];

endmodule

// ===== design/overlay_scaler_register_calc.sv =====
// overlay scaler register calculator: setup transaction in, 17 register writes out
//
// Usage: the s_ channel takes one overlay setup transaction (geometry, format,
// address, pitch, held command bits). The m_ channel emits 17 register-write
// transactions in fixed order, the last one (command word) flagged by last_write.
// Both scale factors come from a 24-cell chain of restoring-division cells,
// one quotient bit per cell. The chain and a side register of the request
// move forward together. At the end, a write sequencer emits one write per
// cycle from an output register while m_ready is high, and loads the next request
// only after the last write of a run. A new request enters the chain while the
// previous run is still being emitted.
// Reset (aresetn low, synchronous) empties the chain and the sequencer.
// When m_ready is low, the output register holds; the chain stalls (and s_ready
// drops) only while a finished request waits at its end for the busy sequencer.
// No transaction is lost.
module overlay_scaler_register_calc import osrc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  osrc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output osrc_out_t m_data
);

    // chain control
    logic      stall;
    osrc_div_t x_in, y_in, x_out, y_out;
    logic [9:0] src_h_in;
    osrc_in_t  side_reg [DivSteps];
    logic [9:0] sh_reg [DivSteps];

    // sequencer state
    logic       busy_reg, busy_next;
    logic [4:0] cnt_reg, cnt_next;
    osrc_in_t   req_reg;
    logic [9:0] sh_hold_reg;
    logic [23:0] xq_reg, yq_reg;
    logic       out_valid_reg, out_valid_next;
    osrc_out_t  out_reg, out_next;
    logic       load;

    assign src_h_in = s_data.deinterlace ? {1'b0, s_data.src_height[9:1]} : s_data.src_height;

    // chain is stalled while its tail result cannot be loaded
    assign load  = x_out.valid && !busy_reg;
    assign stall = x_out.valid && busy_reg;
    assign s_ready = !stall;

    always_comb begin
        x_in.valid = s_valid;
        x_in.num   = {1'b0, s_data.src_width, 12'd0};
        x_in.rem   = '0;
        x_in.quo   = '0;
        x_in.den   = s_data.dst_width;
        y_in.valid = s_valid;
        y_in.num   = {2'b0, src_h_in, 12'd0};
        y_in.rem   = '0;
        y_in.quo   = '0;
        y_in.den   = s_data.dst_height;
    end

    osrc_div_chain u_chain (
        .aclk(aclk), .aresetn(aresetn), .stall(stall),
        .x_in(x_in), .y_in(y_in), .x_out(x_out), .y_out(y_out)
    );

    // request fields travel alongside the chain
    always_ff @(posedge aclk) begin
        if (!stall) begin
            side_reg[0] <= s_data;
            sh_reg[0]   <= src_h_in;
            for (int i = 1; i < DivSteps; i++) begin
                side_reg[i] <= side_reg[i-1];
                sh_reg[i]   <= sh_reg[i-1];
            end
        end
    end

    // derived values of the held request
    logic        planar;
    logic [12:0] sw;
    logic [31:0] swid, swidqw, dwinpos, dwinsz, plane1, plane2, yaddr, uaddr, vaddr;
    logic [31:0] yscale, uvscale, cmd;
    logic [23:0] xf, yf;
    logic [1:0]  xi, yi;
    logic [11:0] xf_uv, yf_uv;
    logic        yi_uv;
    logic [4:0]  bank;
    logic [24:0] area;
    logic [23:0] area2;

    always_comb begin
        planar = (req_reg.pixel_format == FmtI420) || (req_reg.pixel_format == FmtYv12);
        if (planar) begin
            sw     = ({2'b0, req_reg.src_width} + 13'd7) & ~13'd7;
            swid   = ({19'd0, sw} << 15) | {19'd0, sw};
            swidqw = ({19'd0, sw} << 12) | {22'd0, sw[12:3]};
        end else begin
            sw     = {({1'b0, req_reg.src_width} + 12'd3) & ~12'd3, 1'b0};
            swid   = {19'd0, sw};
            swidqw = {22'd0, sw[12:3]};
        end
        dwinpos = {4'd0, req_reg.dst_y, 4'd0, req_reg.dst_x};
        dwinsz  = {4'd0, req_reg.dst_height, 4'd0, req_reg.dst_width};
        area    = req_reg.src_height * req_reg.line_pitch;
        area2   = req_reg.src_height[9:1] * req_reg.line_pitch[14:1];
        yaddr   = req_reg.base_address;
        plane1  = yaddr + {7'd0, area};
        plane2  = plane1 + {8'd0, area2};
        uaddr = '0;
        vaddr = '0;
        if (req_reg.pixel_format == FmtI420) begin
            uaddr = plane1;
            vaddr = plane2;
        end else if (req_reg.pixel_format == FmtYv12) begin
            vaddr = plane1;
            uaddr = plane2;
        end

        // a zero divisor gives an all-ones quotient
        xf = (req_reg.dst_width == 12'd0) ? '1 : xq_reg;
        yf = (req_reg.dst_height == 12'd0) ? '1 : yq_reg;
        xi = xf[13:12];
        yi = yf[13:12];
        cmd = {29'd0, req_reg.held_command_bits} | VcUp | HcUp | YAdj;
        if (req_reg.deinterlace) cmd = cmd | FieldBit;
        yscale  = ScaleOne;
        uvscale = ScaleOne;
        xf_uv = '0;
        yf_uv = '0;
        yi_uv = 1'b0;
        if (req_reg.dst_width != {1'b0, req_reg.src_width} ||
            req_reg.dst_height != {2'b0, sh_hold_reg}) begin
            yscale = {yf[11:0], 3'd0, xi, xf[11:0], 3'd0} | {30'd0, yi};
            if (req_reg.dst_width > {1'b0, req_reg.src_width})
                cmd = (cmd & ~(HcMask | HlMask)) | HcUp | HlUp;
            if (req_reg.dst_height > {2'b0, sh_hold_reg})
                cmd = (cmd & ~(VcMask | VlMask)) | VcUp | VlUp;
            if (req_reg.dst_width < {1'b0, req_reg.src_width})
                cmd = (cmd & ~(HcMask | HlMask)) | HcDown | HlDown;
            if (req_reg.dst_height < {2'b0, sh_hold_reg})
                cmd = (cmd & ~(VcMask | VlMask)) | VcDown | VlDown;
            if (xf != '0) begin
                xf_uv = xf[12:1];
                cmd = (cmd & ~HcDown) | HcUp;
            end
            if (xi[1]) cmd = cmd & ~HcUp;
            if (yf != '0) begin
                yf_uv = yf[12:1];
                cmd = (cmd & ~VcDown) | VcUp;
            end
            if (yi[1]) begin
                yi_uv = 1'b1;
                cmd = (cmd & ~VcUp) | VcDown;
            end
            uvscale = {yf_uv, 5'd0, xf_uv, 3'd0} | {31'd0, yi_uv};
        end
        cmd = cmd & ~FmtMask;
        if (planar) begin
            cmd = cmd | Fmt420;
        end else begin
            cmd = (cmd | Fmt422) & ~ByteOrder;
            if (req_reg.pixel_format == FmtUyvy) cmd = cmd | YSwap;
        end
        bank = req_reg.held_command_bits[2] ? 5'd9 : 5'd6;
    end

    // next write of the run
    always_comb begin
        out_next.last_write = 1'b0;
        unique case (cnt_reg)
            5'd0: begin out_next.register_index = 5'd0; out_next.register_value = swid; end
            5'd1: begin out_next.register_index = 5'd1; out_next.register_value = swidqw; end
            5'd2: begin
                out_next.register_index = 5'd2;
                out_next.register_value = {7'd0, sh_hold_reg, 5'd0, sh_hold_reg};
            end
            5'd3: begin
                out_next.register_index = 5'd3;
                out_next.register_value = {31'd0, sw > {1'b0, LineBufLimit}};
            end
            5'd4: begin out_next.register_index = 5'd4; out_next.register_value = dwinpos; end
            5'd5: begin out_next.register_index = 5'd5; out_next.register_value = dwinsz; end
            5'd6: begin out_next.register_index = bank; out_next.register_value = yaddr; end
            5'd7: begin
                out_next.register_index = bank + 5'd1; out_next.register_value = vaddr;
            end
            5'd8: begin
                out_next.register_index = bank + 5'd2; out_next.register_value = uaddr;
            end
            5'd9: begin out_next.register_index = 5'd12; out_next.register_value = yscale; end
            5'd10: begin out_next.register_index = 5'd13; out_next.register_value = uvscale; end
            5'd11: begin
                out_next.register_index = 5'd14;
                out_next.register_value = planar ? Phase420 : 32'd0;
            end
            5'd12: begin
                out_next.register_index = 5'd15;
                out_next.register_value = planar ? 32'd6 : 32'd0;
            end
            5'd13: begin
                out_next.register_index = 5'd16;
                out_next.register_value = planar
                    ? {2'd0, req_reg.line_pitch, req_reg.line_pitch}
                    : {17'd0, req_reg.line_pitch};
            end
            5'd14: begin out_next.register_index = 5'd17; out_next.register_value = dwinpos; end
            5'd15: begin out_next.register_index = 5'd18; out_next.register_value = dwinsz; end
            default: begin
                out_next.register_index = 5'd19;
                out_next.register_value = cmd;
                out_next.last_write = 1'b1;
            end
        endcase
    end

    // sequencer control
    logic adv;
    assign adv = busy_reg && (!out_valid_reg || m_ready);
    always_comb begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (adv) begin
            out_valid_next = 1'b1;
            if (cnt_reg == 5'(NumWrites - 1)) begin
                busy_next = 1'b0;
                cnt_next  = '0;
            end else begin
                cnt_next = cnt_reg + 5'd1;
            end
        end
        if (load) busy_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) out_reg <= out_next;
        if (load) begin
            req_reg     <= side_reg[DivSteps-1];
            sh_hold_reg <= sh_reg[DivSteps-1];
            xq_reg      <= x_out.quo;
            yq_reg      <= y_out.quo;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== design/osrc_checker.sv =====
// port-level checker for the overlay scaler register calculator
`include "overlay_scaler_register_calc_defines.svh"
module osrc_checker import osrc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input osrc_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input osrc_out_t m_data
);
    `OSRC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `OSRC_ASSERT_IMP(a_last_idx, aclk, aresetn, m_valid && m_data.last_write,
        m_data.register_index == 5'd19)
    `OSRC_ASSERT_IMP(a_idx_range, aclk, aresetn, m_valid, m_data.register_index <= 5'd19)
    `OSRC_ASSERT_NEXT(a_after_last, aclk, aresetn, m_valid && m_ready && m_data.last_write,
        !m_valid || m_data.register_index == 5'd0)
endmodule

bind overlay_scaler_register_calc osrc_checker u_osrc_checker (.*);

// ===== bench/overlay_scaler_register_calc_tb.sv =====
// testbench for the overlay scaler register calculator: random and directed setups, scoreboard check
module overlay_scaler_register_calc_tb;
    import osrc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // expected register writes of all accepted setup transactions
    class write_scoreboard;
        osrc_out_t pending[$];
        int errors = 0;

        function logic [31:0] divide(logic [31:0] a, logic [31:0] b);
            return (b == 0) ? 32'hFFFF_FFFF : a / b;
        endfunction

        function void push(logic [4:0] idx, logic [31:0] val, logic lst);
            osrc_out_t w;
            w.register_index = idx;
            w.register_value = val;
            w.last_write = lst;
            pending.push_back(w);
        endfunction

        // note an accepted setup and derive its 17 writes
        function void note_setup(osrc_in_t r);
            logic planar;
            logic [31:0] src_w, src_h, full_h, dw, dh, pitch, base;
            logic [31:0] sw, swid, swidqw, yaddr, uaddr, vaddr, yscale, uvscale, cmd;
            logic [31:0] dwinpos, dwinsz, xi, xf, yi, yf, xf_uv, yf_uv, yi_uv;
            logic [4:0] bank;
            src_w = r.src_width;
            full_h = r.src_height;
            dw = r.dst_width;
            dh = r.dst_height;
            pitch = r.line_pitch;
            base = r.base_address;
            planar = (r.pixel_format == FmtI420) || (r.pixel_format == FmtYv12);
            src_h = r.deinterlace ? (full_h >> 1) : full_h;
            uaddr = 0;
            vaddr = 0;
            yscale = ScaleOne;
            uvscale = ScaleOne;
            if (planar) begin
                sw = (src_w + 7) & ~32'd7;
                swid = (sw << 15) | sw;
                swidqw = (sw << 12) | (sw >> 3);
            end else begin
                sw = ((src_w + 3) & ~32'd3) << 1;
                swid = sw;
                swidqw = sw >> 3;
            end
            dwinpos = ({20'd0, r.dst_y} << 16) | r.dst_x;
            dwinsz = (dh << 16) | dw;
            yaddr = base;
            if (r.pixel_format == FmtI420) begin
                uaddr = yaddr + full_h * pitch;
                vaddr = uaddr + (full_h >> 1) * (pitch >> 1);
            end else if (r.pixel_format == FmtYv12) begin
                vaddr = yaddr + full_h * pitch;
                uaddr = vaddr + (full_h >> 1) * (pitch >> 1);
            end
            cmd = r.held_command_bits | VcUp | HcUp | YAdj;
            if (r.deinterlace) cmd |= FieldBit;
            // scale factors and filter mode bits
            if (dw != src_w || dh != src_h) begin
                xi = divide(src_w, dw) & 3;
                xf = divide(src_w << 12, dw);
                yi = divide(src_h, dh) & 3;
                yf = divide(src_h << 12, dh);
                xf_uv = 0;
                yf_uv = 0;
                yi_uv = 0;
                yscale = (xi << 15) | ((xf & 32'hFFF) << 3) | yi | ((yf & 32'hFFF) << 20);
                if (dw > src_w) cmd = (cmd & ~(HcMask | HlMask)) | HcUp | HlUp;
                if (dh > src_h) cmd = (cmd & ~(VcMask | VlMask)) | VcUp | VlUp;
                if (dw < src_w) cmd = (cmd & ~(HcMask | HlMask)) | HcDown | HlDown;
                if (dh < src_h) cmd = (cmd & ~(VcMask | VlMask)) | VcDown | VlDown;
                if (xf != 0) begin
                    xf_uv = xf >> 1;
                    cmd = (cmd & ~HcDown) | HcUp;
                end
                if ((xi >> 1) != 0) cmd &= ~HcUp;
                if (yf != 0) begin
                    yf_uv = yf >> 1;
                    cmd = (cmd & ~VcDown) | VcUp;
                end
                if (yi != 0) begin
                    yi_uv = yi >> 1;
                    if (yi_uv != 0) cmd = (cmd & ~VcUp) | VcDown;
                end
                uvscale = yi_uv | ((xf_uv & 32'hFFF) << 3) | ((yf_uv & 32'hFFF) << 20);
            end
            cmd &= ~FmtMask;
            if (planar) begin
                cmd |= Fmt420;
            end else begin
                cmd |= Fmt422;
                cmd &= ~ByteOrder;
                if (r.pixel_format == FmtUyvy) cmd |= YSwap;
            end
            bank = r.held_command_bits[2] ? 5'd9 : 5'd6;
            push(5'd0, swid, 0);
            push(5'd1, swidqw, 0);
            push(5'd2, src_h | (src_h << 15), 0);
            push(5'd3, (sw > LineBufLimit) ? 32'd1 : 32'd0, 0);
            push(5'd4, dwinpos, 0);
            push(5'd5, dwinsz, 0);
            push(bank, yaddr, 0);
            push(bank + 5'd1, vaddr, 0);
            push(bank + 5'd2, uaddr, 0);
            push(5'd12, yscale, 0);
            push(5'd13, uvscale, 0);
            push(5'd14, planar ? Phase420 : 32'd0, 0);
            push(5'd15, planar ? 32'd6 : 32'd0, 0);
            push(5'd16, planar ? (pitch | (pitch << 15)) : pitch, 0);
            push(5'd17, dwinpos, 0);
            push(5'd18, dwinsz, 0);
            push(5'd19, cmd, 1);
        endfunction

        // compare one register write against the oldest expectation
        function void check_write(osrc_out_t got);
            osrc_out_t exp_w;
            if (pending.size() == 0) begin
                $error("unexpected write index %0d value %h", got.register_index,
                       got.register_value);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.register_index !== exp_w.register_index) begin
                $error("register_index expected %0d actual %0d", exp_w.register_index,
                       got.register_index);
                errors++;
            end
            if (got.register_value !== exp_w.register_value) begin
                $error("register_value expected %h actual %h", exp_w.register_value,
                       got.register_value);
                errors++;
            end
            if (got.last_write !== exp_w.last_write) begin
                $error("last_write expected %0d actual %0d", exp_w.last_write,
                       got.last_write);
                errors++;
            end
        endfunction
    endclass

    localparam int RandomSetups = 410;
    localparam int WatchdogLimit = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    osrc_in_t s_data;
    logic m_valid;
    logic m_ready;
    osrc_out_t m_data;
    logic sending_done;
    int idle_cycles;
    write_scoreboard board;

    overlay_scaler_register_calc dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // half the time no gap, otherwise mostly short gaps and a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one setup transaction and wait for acceptance
    task automatic send_setup(osrc_in_t r);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_setup(r);
    endtask

    function automatic osrc_in_t random_setup();
        osrc_in_t r;
        int mode;
        r = '0;
        r.src_width = $urandom_range(1, 1440);
        r.src_height = $urandom_range(1, 1023);
        r.dst_x = $urandom;
        r.dst_y = $urandom;
        r.pixel_format = $urandom;
        r.deinterlace = $urandom;
        r.base_address = $urandom;
        r.line_pitch = $urandom;
        r.held_command_bits = $urandom;
        mode = $urandom_range(0, 9);
        // sometimes unscaled, sometimes width kept or doubled, otherwise anywhere
        if (mode == 0) begin
            r.dst_width = r.src_width;
            r.dst_height = r.deinterlace ? (r.src_height >> 1) : r.src_height;
        end else if (mode < 4) begin
            r.dst_width = r.src_width * $urandom_range(1, 2);
            r.dst_height = $urandom_range(1, 1023);
        end else begin
            r.dst_width = $urandom;
            r.dst_height = $urandom;
        end
        if ($urandom_range(0, 40) == 0) r.dst_width = 0;
        if ($urandom_range(0, 40) == 0) r.dst_height = 0;
        return r;
    endfunction

    function automatic osrc_in_t make_setup(int sw, int sh, int dw, int dh,
                                            logic [1:0] fmt, logic deint,
                                            logic [31:0] base, int pitch, int held);
        osrc_in_t r;
        r = '0;
        r.src_width = sw;
        r.src_height = sh;
        r.dst_width = dw;
        r.dst_height = dh;
        r.dst_x = $urandom;
        r.dst_y = $urandom;
        r.pixel_format = fmt;
        r.deinterlace = deint;
        r.base_address = base;
        r.line_pitch = pitch;
        r.held_command_bits = held;
        return r;
    endfunction

    // stimulus
    initial begin
        osrc_in_t r;
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        sending_done = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: every format, extremes, zero divisors, halved height of zero
        send_setup(make_setup(1, 1, 1, 1, FmtI420, 0, 32'h0, 0, 0));
        send_setup(make_setup(1440, 1023, 4095, 4095, FmtYv12, 0, 32'hFFFF_FFFF, 32767, 7));
        send_setup(make_setup(1440, 1023, 1, 1, FmtYuy2, 1, 32'hFFFF_0000, 32767, 4));
        send_setup(make_setup(1440, 1023, 1, 1, FmtUyvy, 0, 32'h1234_5678, 100, 3));
        send_setup(make_setup(720, 480, 0, 240, FmtI420, 1, 32'h8000_0000, 1440, 1));
        send_setup(make_setup(720, 480, 360, 0, FmtYv12, 0, 32'h0, 720, 2));
        send_setup(make_setup(100, 1, 100, 1, FmtI420, 1, 32'h0, 64, 5));
        send_setup(make_setup(100, 1, 50, 0, FmtUyvy, 1, 32'h0, 64, 6));
        send_setup(make_setup(721, 576, 721, 576, FmtYuy2, 0, 32'hFFFF_FFF0, 1442, 0));
        send_setup(make_setup(713, 300, 2000, 100, FmtI420, 0, 32'hFFFF_FF00, 32767, 4));
        send_setup(make_setup(1440, 1023, 4095, 4095, FmtUyvy, 1, 32'h5555_AAAA, 21845, 7));
        send_setup(make_setup(1033, 682, 1033, 341, FmtYv12, 1, 32'hAAAA_5555, 10922, 2));
        // sender holds off until all writes have come back
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        for (int i = 0; i < RandomSetups; i++) begin
            r = random_setup();
            send_setup(r);
        end
        s_valid <= 1'b0;
        sending_done <= 1'b1;
    end

    // result side: random ready, check every accepted write
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            g = gap_length();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if (m_valid) board.check_write(m_data);
        end
    end

    // watchdog and end of run
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (sending_done && board.pending.size() == 0) begin
                repeat (60) @(posedge aclk);
                if (board.errors == 0 && board.pending.size() == 0) $display("SUCCESS");
                else $display("FAILURE");
                $finish;
            end else if (idle_cycles >= WatchdogLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end
endmodule
